/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// Depends on signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gdda check failed");
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gdda reset check failed");
`else
`define ASSERT_CHK(label, prop)
`define ASSERT_RST(label, prop)
`endif
`endif

/* sv/gdda_pkg.sv */
// Shared types, widths and codes for the grid ray caster.
// No dependencies.
package gdda_pkg;
  localparam int MAP_SIZE_DEF = 32;
  localparam int FRAC_BITS    = 16;
  localparam int FRAC_ONE     = 65536;
  localparam int POS_W        = 21;
  localparam int DIR_W        = 19;
  localparam int SW_W         = 13;
  localparam int COL_W        = 12;
  localparam int CELL_W       = 5;
  localparam int VAL_W        = 8;
  localparam int DIST_W       = 24;
  localparam int CAM_W        = 32;
  localparam int PROD_W       = 51;
  localparam int RAY_W        = 34;
  localparam int DELTA_W      = 33;
  localparam int FRAC_W       = 17;
  localparam int DIVN_W       = 48;
  localparam int DIVD_W       = 34;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 21;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y,
    CFG_PLANE_X, CFG_PLANE_Y, CFG_SCREEN_WIDTH
  } cfg_reg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_WRITE, CMD_LOAD, CMD_DIV_CAM, CMD_CAM, CMD_MUL,
    CMD_RAY, CMD_DIV_X, CMD_DX, CMD_DIV_Y, CMD_DY, CMD_SIDE, CMD_STEP,
    CMD_DIV_DIST, CMD_DIST, CMD_OUT_HIT, CMD_OUT_ESC
  } cmd_t;

  typedef struct packed {
    cmd_t op;
    logic div_start;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic div_done;
    logic bad_start;
    logic rx_zero;
    logic ry_zero;
    logic step_limit;
    logic m_oob;
    logic cell_hit;
    logic out_free;
  } status_t;
endpackage

/* sv/gdda_if.sv */
// Handshake channels of the grid ray caster: items, results, config writes.
// Depends on gdda_pkg.
interface gdda_item_if import gdda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [COL_W-1:0]  column;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [VAL_W-1:0]  cell_value;
  modport source (output valid, opcode, column, cell_x, cell_y, cell_value, input ready);
  modport sink (input valid, opcode, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface gdda_result_if import gdda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] hit_x;
  logic [CELL_W-1:0] hit_y;
  logic [VAL_W-1:0]  wall_value;
  logic              hit_side;
  logic [DIST_W-1:0] wall_distance;
  logic              escaped;
  modport source (output valid, hit_x, hit_y, wall_value, hit_side, wall_distance,
                  escaped, input ready);
  modport sink (input valid, hit_x, hit_y, wall_value, hit_side, wall_distance,
                escaped, output ready);
endinterface

interface gdda_cfg_if import gdda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/gdda_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module gdda_div #(
  parameter int NW = 48,
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          busy,
  output logic          done
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem;
  logic [DW-1:0]   dreg;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;
  logic            qbit;

  assign trial = {rem[DW-1:0], quo[NW-1]};
  assign qbit  = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= qbit ? (trial - {1'b0, dreg}) : trial;
      quo <= {quo[NW-2:0], qbit};
    end
  end
endmodule

/* sv/gdda_dp.sv */
// Datapath: config registers, tile map memory, ray setup, DDA walk, divider.
// Depends on gdda_pkg and gdda_div.
module gdda_dp import gdda_pkg::*; #(
  parameter int MAP_SIZE = MAP_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  output status_t               st,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COL_W-1:0]      column,
  input  logic [CELL_W-1:0]     cell_x,
  input  logic [CELL_W-1:0]     cell_y,
  input  logic [VAL_W-1:0]      cell_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CELL_W-1:0]     hit_x,
  output logic [CELL_W-1:0]     hit_y,
  output logic [VAL_W-1:0]      wall_value,
  output logic                  hit_side,
  output logic [DIST_W-1:0]     wall_distance,
  output logic                  escaped
);
  localparam int CW       = $clog2(MAP_SIZE);
  localparam int CWX      = (CW > CELL_W) ? CW : CELL_W;
  localparam int MCW      = CWX + 2;
  localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
  localparam int AW       = $clog2(DEPTH);
  localparam int STEP_MAX = 2 * MAP_SIZE + 2;
  localparam int SCW      = $clog2(STEP_MAX + 1);
  localparam int SDW      = DELTA_W + SCW + 2;
  localparam int DNW      = MCW + 17;
  localparam int PSW      = FRAC_W + DELTA_W;

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [SW_W-1:0]         screen_width;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     waddr, addr_n;
  logic              wr_in_map;

  logic [COL_W-1:0]         col;
  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [RAY_W-1:0]  rx, ry;
  logic [RAY_W-1:0]         abs_rx, abs_ry;
  logic                     rx_neg, ry_neg;
  logic [DELTA_W-1:0]       dx, dy;
  logic [FRAC_W-1:0]        frac_x, frac_y;
  logic [PSW-1:0]           psx, psy;
  logic [SDW-1:0]           sdx, sdy;
  logic signed [MCW-1:0]    mx, my, mx_n, my_n;
  logic                     side, stepx, oob_n, m_oob;
  logic [SCW-1:0]           cnt;
  logic signed [DNW-1:0]    dnum;
  logic [DNW-1:0]           abs_dnum;
  logic [DIST_W-1:0]        dist_sat;
  logic [SW_W-1:0]          w_eff;

  logic [DIVN_W-1:0] div_num, div_q;
  logic [DIVD_W-1:0] div_den;
  logic              div_busy, div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= POS_W'(1048576);
      pos_y        <= POS_W'(1048576);
      dir_x        <= -DIR_W'(65536);
      dir_y        <= '0;
      plane_x      <= '0;
      plane_y      <= DIR_W'(43253);
      screen_width <= SW_W'(320);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POS_X:        pos_x        <= cfg_data[POS_W-1:0];
        CFG_POS_Y:        pos_y        <= cfg_data[POS_W-1:0];
        CFG_DIR_X:        dir_x        <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:        dir_y        <= cfg_data[DIR_W-1:0];
        CFG_PLANE_X:      plane_x      <= cfg_data[DIR_W-1:0];
        CFG_PLANE_Y:      plane_y      <= cfg_data[DIR_W-1:0];
        CFG_SCREEN_WIDTH: screen_width <= cfg_data[SW_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff  = (screen_width == '0) ? SW_W'(1) : screen_width;
  assign rx_neg = rx[RAY_W-1];
  assign ry_neg = ry[RAY_W-1];
  assign abs_rx = rx_neg ? RAY_W'(-rx) : RAY_W'(rx);
  assign abs_ry = ry_neg ? RAY_W'(-ry) : RAY_W'(ry);

  assign frac_x = rx_neg ? {1'b0, pos_x[FRAC_BITS-1:0]}
                         : FRAC_W'(FRAC_ONE) - {1'b0, pos_x[FRAC_BITS-1:0]};
  assign frac_y = ry_neg ? {1'b0, pos_y[FRAC_BITS-1:0]}
                         : FRAC_W'(FRAC_ONE) - {1'b0, pos_y[FRAC_BITS-1:0]};
  assign psx = PSW'(frac_x) * PSW'(dx);
  assign psy = PSW'(frac_y) * PSW'(dy);

  // ties step in y
  always_comb begin
    if (st.rx_zero)      stepx = 1'b0;
    else if (st.ry_zero) stepx = 1'b1;
    else                 stepx = (sdx < sdy);
    mx_n = mx;
    my_n = my;
    if (stepx) mx_n = rx_neg ? mx - MCW'(1) : mx + MCW'(1);
    else       my_n = ry_neg ? my - MCW'(1) : my + MCW'(1);
    oob_n = (mx_n < 0) || (32'(mx_n) >= MAP_SIZE) || (my_n < 0) || (32'(my_n) >= MAP_SIZE);
    addr_n = oob_n ? '0 : AW'(32'(mx_n) * MAP_SIZE + 32'(my_n));
  end

  always_comb begin
    if (!side) dnum = (DNW'(mx) <<< FRAC_BITS) - DNW'(signed'({1'b0, pos_x}))
                      + (rx_neg ? DNW'(FRAC_ONE) : DNW'(0));
    else       dnum = (DNW'(my) <<< FRAC_BITS) - DNW'(signed'({1'b0, pos_y}))
                      + (ry_neg ? DNW'(FRAC_ONE) : DNW'(0));
    abs_dnum = dnum[DNW-1] ? DNW'(-dnum) : DNW'(dnum);
  end

  always_comb begin
    case (ctrl.op)
      CMD_DIV_X:    begin div_num = DIVN_W'(1) << 32; div_den = abs_rx; end
      CMD_DIV_Y:    begin div_num = DIVN_W'(1) << 32; div_den = abs_ry; end
      CMD_DIV_DIST: begin
        div_num = DIVN_W'(abs_dnum) << FRAC_BITS;
        div_den = side ? abs_ry : abs_rx;
      end
      default:      begin div_num = DIVN_W'({col, 17'd0}); div_den = DIVD_W'(w_eff); end
    endcase
  end

  gdda_div #(.NW(DIVN_W), .DW(DIVD_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .busy  (div_busy),
    .done  (div_done)
  );

  assign waddr     = AW'(32'(cell_x) * MAP_SIZE + 32'(cell_y));
  assign wr_in_map = (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE);

  always_ff @(posedge clk) begin
    if (ctrl.op == CMD_CLEAR)
      mem[clr_addr] <= '0;
    else if (ctrl.op == CMD_WRITE && wr_in_map)
      mem[waddr] <= cell_value;
    if (ctrl.op == CMD_STEP)
      rdata <= mem[addr_n];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (ctrl.op == CMD_CLEAR) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CMD_LOAD: col <= column;
      CMD_CAM:  cam <= signed'(div_q[CAM_W-1:0] - CAM_W'(FRAC_ONE));
      CMD_MUL: begin
        prod_x <= plane_x * cam;
        prod_y <= plane_y * cam;
      end
      CMD_RAY: begin
        rx   <= RAY_W'(dir_x) + prod_x[FRAC_BITS+RAY_W-1:FRAC_BITS];
        ry   <= RAY_W'(dir_y) + prod_y[FRAC_BITS+RAY_W-1:FRAC_BITS];
        mx   <= MCW'(pos_x[POS_W-1:FRAC_BITS]);
        my   <= MCW'(pos_y[POS_W-1:FRAC_BITS]);
        side <= 1'b0;
        cnt  <= '0;
      end
      CMD_DX:   dx <= div_q[DELTA_W-1:0];
      CMD_DY:   dy <= div_q[DELTA_W-1:0];
      CMD_SIDE: begin
        sdx <= SDW'(psx[PSW-1:FRAC_BITS]);
        sdy <= SDW'(psy[PSW-1:FRAC_BITS]);
      end
      CMD_STEP: begin
        if (stepx) sdx <= sdx + SDW'(dx);
        else       sdy <= sdy + SDW'(dy);
        mx    <= mx_n;
        my    <= my_n;
        side  <= !stepx;
        m_oob <= oob_n;
        cnt   <= cnt + 1'b1;
      end
      CMD_DIST: dist_sat <= (|div_q[DIVN_W-1:DIST_W]) ? '1 : div_q[DIST_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == CMD_OUT_HIT || ctrl.op == CMD_OUT_ESC) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == CMD_OUT_HIT) begin
      hit_x         <= mx[CELL_W-1:0];
      hit_y         <= my[CELL_W-1:0];
      wall_value    <= rdata;
      hit_side      <= side;
      wall_distance <= dist_sat;
      escaped       <= 1'b0;
    end else if (ctrl.op == CMD_OUT_ESC) begin
      hit_x         <= '0;
      hit_y         <= '0;
      wall_value    <= '0;
      hit_side      <= 1'b0;
      wall_distance <= '0;
      escaped       <= 1'b1;
    end
  end

  always_comb begin
    st.clear_last = (clr_addr == AW'(DEPTH - 1));
    st.div_busy   = div_busy;
    st.div_done   = div_done;
    st.rx_zero    = (rx == '0);
    st.ry_zero    = (ry == '0);
    st.bad_start  = (32'(mx) >= MAP_SIZE) || (32'(my) >= MAP_SIZE) ||
                    ((rx == '0) && (ry == '0));
    st.step_limit = (32'(cnt) == STEP_MAX);
    st.m_oob      = m_oob;
    st.cell_hit   = (rdata != '0);
    st.out_free   = !out_valid || out_ready;
  end
endmodule

/* sv/gdda_ctrl.sv */
// Controller: sequences map clear, writes and the per-ray setup and walk.
// Depends on gdda_pkg.
module gdda_ctrl import gdda_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  output ctrl_t   ctrl,
  input  status_t st
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_CAM_W, S_MUL, S_RAY, S_CHECK, S_DX, S_DX_W,
    S_DY, S_DY_W, S_SIDE, S_STEP, S_PROBE, S_DIST, S_DIST_W, S_OUT_HIT, S_OUT_ESC
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    ctrl.op        = CMD_NONE;
    ctrl.div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        ctrl.op = CMD_CLEAR;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_CAST) begin
            ctrl.op    = CMD_LOAD;
            state_next = S_CAM;
          end else begin
            ctrl.op = CMD_WRITE;
          end
        end
      end
      S_CAM: begin
        ctrl.op        = CMD_DIV_CAM;
        ctrl.div_start = 1'b1;
        state_next     = S_CAM_W;
      end
      S_CAM_W: begin
        if (st.div_done) begin
          ctrl.op    = CMD_CAM;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.op    = CMD_MUL;
        state_next = S_RAY;
      end
      S_RAY: begin
        ctrl.op    = CMD_RAY;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = st.bad_start ? S_OUT_ESC : S_DX;
      S_DX: begin
        if (st.rx_zero) begin
          state_next = S_DY;
        end else begin
          ctrl.op        = CMD_DIV_X;
          ctrl.div_start = 1'b1;
          state_next     = S_DX_W;
        end
      end
      S_DX_W: begin
        if (st.div_done) begin
          ctrl.op    = CMD_DX;
          state_next = S_DY;
        end
      end
      S_DY: begin
        if (st.ry_zero) begin
          state_next = S_SIDE;
        end else begin
          ctrl.op        = CMD_DIV_Y;
          ctrl.div_start = 1'b1;
          state_next     = S_DY_W;
        end
      end
      S_DY_W: begin
        if (st.div_done) begin
          ctrl.op    = CMD_DY;
          state_next = S_SIDE;
        end
      end
      S_SIDE: begin
        ctrl.op    = CMD_SIDE;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (st.step_limit) begin
          state_next = S_OUT_ESC;
        end else begin
          ctrl.op    = CMD_STEP;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (st.m_oob)         state_next = S_OUT_ESC;
        else if (st.cell_hit) state_next = S_DIST;
        else                  state_next = S_STEP;
      end
      S_DIST: begin
        ctrl.op        = CMD_DIV_DIST;
        ctrl.div_start = 1'b1;
        state_next     = S_DIST_W;
      end
      S_DIST_W: begin
        if (st.div_done) begin
          ctrl.op    = CMD_DIST;
          state_next = S_OUT_HIT;
        end
      end
      S_OUT_HIT: begin
        if (st.out_free) begin
          ctrl.op    = CMD_OUT_HIT;
          state_next = S_IDLE;
        end
      end
      S_OUT_ESC: begin
        if (st.out_free) begin
          ctrl.op    = CMD_OUT_ESC;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end
endmodule

/* sv/grid_ray_caster_dda.sv */
// Top level of the grid ray caster: controller, datapath and port wiring.
// Depends on gdda_pkg, the gdda interfaces, gdda_ctrl, gdda_dp, assert_macros.svh.
//
// After reset the tile map is swept to empty, one cell per cycle; items wait,
// configuration writes are taken. During a cast the shared divider runs for the camera
// coordinate, for each nonzero ray component and for the wall distance of a hit, and
// the grid walk takes a step, then a registered map read, for each cell, at most
// 2*MAP_SIZE+2 cells. A ray rejected at setup skips the walk and gives an escaped result.
// A finished result sits in the output register while the next item is taken.
`include "assert_macros.svh"

module grid_ray_caster_dda import gdda_pkg::*; #(
  parameter int MAP_SIZE = MAP_SIZE_DEF
) (
  input logic           clk,
  input logic           rst,
  gdda_item_if.sink     item,
  gdda_result_if.source result,
  gdda_cfg_if.sink      cfg
);
  ctrl_t   ctrl;
  status_t st;

  assign cfg.ready = 1'b1;

  gdda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_opcode (item.opcode),
    .in_ready  (item.ready),
    .ctrl      (ctrl),
    .st        (st)
  );

  gdda_dp #(.MAP_SIZE(MAP_SIZE)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .st            (st),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .column        (item.column),
    .cell_x        (item.cell_x),
    .cell_y        (item.cell_y),
    .cell_value    (item.cell_value),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .hit_x         (result.hit_x),
    .hit_y         (result.hit_y),
    .wall_value    (result.wall_value),
    .hit_side      (result.hit_side),
    .wall_distance (result.wall_distance),
    .escaped       (result.escaped)
  );

  `ASSERT_CHK(a_div_start_free, ctrl.div_start |-> !st.div_busy)
  `ASSERT_CHK(a_cast_leaves_idle, (item.valid && item.ready && item.opcode) |=> !item.ready)
  `ASSERT_CHK(a_load_needs_slot, (ctrl.op == CMD_OUT_HIT || ctrl.op == CMD_OUT_ESC) |-> st.out_free)
  `ASSERT_RST(a_reset_empties_out, $past(rst) |-> !result.valid)
endmodule

/* test/gdda_checker.sv */
`timescale 1ns / 1ps
// Checker for the grid ray caster: watches item, result and config beats,
// predicts each cast and compares. Depends on gdda_pkg and the gdda interfaces.
module gdda_checker import gdda_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  gdda_item_if   item,
  gdda_result_if result,
  gdda_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding
);
  localparam int CELLS = MAP_SIZE_DEF;

  typedef struct packed {
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic [VAL_W-1:0]  wall_value;
    logic              hit_side;
    logic [DIST_W-1:0] wall_distance;
    logic              escaped;
  } ray_hit_t;

  logic [VAL_W-1:0] cells [CELLS*CELLS];
  longint unsigned pos_x_r, pos_y_r, width_r;
  longint dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  ray_hit_t pending_hits [$];

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic ray_hit_t trace_ray(logic [COL_W-1:0] col);
    ray_hit_t r;
    longint cam, rx, ry, mx, my, sx, sy, num;
    longint unsigned w, tmp, dx, dy, sdx, sdy, dist_q, den;
    bit hit, stepx;
    int side;
    r = '0;
    r.escaped = 1'b1;
    hit = 0;
    side = 0;
    dx = 0;
    dy = 0;
    w = (width_r == 0) ? 1 : width_r;
    tmp = (longint'(col) * 2 * FRAC_ONE) / w;
    cam = longint'(tmp) - FRAC_ONE;
    rx = dir_x_r + ((plane_x_r * cam) >>> FRAC_BITS);
    ry = dir_y_r + ((plane_y_r * cam) >>> FRAC_BITS);
    mx = longint'(pos_x_r >> FRAC_BITS);
    my = longint'(pos_y_r >> FRAC_BITS);
    if (mx >= CELLS || my >= CELLS || (rx == 0 && ry == 0)) return r;
    if (rx != 0) dx = (64'd1 << 32) / mag(rx);
    if (ry != 0) dy = (64'd1 << 32) / mag(ry);
    if (rx < 0) begin
      sx = -1;
      sdx = ((pos_x_r - longint'(mx) * FRAC_ONE) * dx) >> FRAC_BITS;
    end else begin
      sx = 1;
      sdx = ((longint'(mx) * FRAC_ONE + FRAC_ONE - pos_x_r) * dx) >> FRAC_BITS;
    end
    if (ry < 0) begin
      sy = -1;
      sdy = ((pos_y_r - longint'(my) * FRAC_ONE) * dy) >> FRAC_BITS;
    end else begin
      sy = 1;
      sdy = ((longint'(my) * FRAC_ONE + FRAC_ONE - pos_y_r) * dy) >> FRAC_BITS;
    end
    for (int n = 0; n < 2 * CELLS + 2; n++) begin
      if (rx == 0) stepx = 0;
      else if (ry == 0) stepx = 1;
      else stepx = sdx < sdy;
      if (stepx) begin
        sdx += dx;
        mx += sx;
        side = 0;
      end else begin
        sdy += dy;
        my += sy;
        side = 1;
      end
      if (mx < 0 || mx >= CELLS || my < 0 || my >= CELLS) return r;
      if (cells[mx * CELLS + my] != 0) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return r;
    if (side == 0) begin
      num = mx * FRAC_ONE - longint'(pos_x_r) + ((sx < 0) ? FRAC_ONE : 0);
      den = mag(rx);
    end else begin
      num = my * FRAC_ONE - longint'(pos_y_r) + ((sy < 0) ? FRAC_ONE : 0);
      den = mag(ry);
    end
    dist_q = (mag(num) * FRAC_ONE) / den;
    if (dist_q > 64'hFFFFFF) dist_q = 64'hFFFFFF;
    r.hit_x = mx[CELL_W-1:0];
    r.hit_y = my[CELL_W-1:0];
    r.wall_value = cells[mx * CELLS + my];
    r.hit_side = side[0];
    r.wall_distance = dist_q[DIST_W-1:0];
    r.escaped = 1'b0;
    return r;
  endfunction

  function automatic longint sext19(logic [CFG_DATA_W-1:0] d);
    return longint'(signed'(d[DIR_W-1:0]));
  endfunction

  always @(posedge clk) begin
    ray_hit_t got, want;
    if (rst) begin
      foreach (cells[i]) cells[i] = '0;
      pos_x_r = 1048576;
      pos_y_r = 1048576;
      dir_x_r = -65536;
      dir_y_r = 0;
      plane_x_r = 0;
      plane_y_r = 43253;
      width_r = 320;
      mismatches = 0;
      pending_hits.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.hit_x, result.hit_y, result.wall_value, result.hit_side,
                result.wall_distance, result.escaped};
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = pending_hits.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d y=%0d v=%0d s=%0d d=%0d e=%0d | got x=%0d y=%0d v=%0d s=%0d d=%0d e=%0d",
                       want.hit_x, want.hit_y, want.wall_value, want.hit_side,
                       want.wall_distance, want.escaped, got.hit_x, got.hit_y,
                       got.wall_value, got.hit_side, got.wall_distance, got.escaped);
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.opcode == OP_WRITE)
          cells[int'(item.cell_x) * CELLS + int'(item.cell_y)] = item.cell_value;
        else
          pending_hits.push_back(trace_ray(item.column));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_POS_X:        pos_x_r = cfg.data;
          CFG_POS_Y:        pos_y_r = cfg.data;
          CFG_DIR_X:        dir_x_r = sext19(cfg.data);
          CFG_DIR_Y:        dir_y_r = sext19(cfg.data);
          CFG_PLANE_X:      plane_x_r = sext19(cfg.data);
          CFG_PLANE_Y:      plane_y_r = sext19(cfg.data);
          CFG_SCREEN_WIDTH: width_r = cfg.data[SW_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_hits.size();
  end
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for grid_ray_caster_dda: clock, reset, stimulus and verdict.
// Depends on gdda_pkg, the gdda interfaces, gdda_checker and the block.
module tb_top;
  import gdda_pkg::*;

  localparam int TARGET_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 0;
  logic rst;
  int   mismatches, outstanding;
  int   idle_pct, stall_pct;
  int   hold_req;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   items_sent;
  int   cycles = 0;

  gdda_item_if   item_ch ();
  gdda_result_if res_ch ();
  gdda_cfg_if    cfg_ch ();

  grid_ray_caster_dda uut (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
  );

  gdda_checker chk (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch), .cfg(cfg_ch),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall, plus long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 800;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(logic op, logic [COL_W-1:0] col, logic [CELL_W-1:0] cx,
                           logic [CELL_W-1:0] cy, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.column     <= col;
    item_ch.cell_x     <= cx;
    item_ch.cell_y     <= cy;
    item_ch.cell_value <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cast(logic [COL_W-1:0] col);
    send_item(OP_CAST, col, CELL_W'($urandom), CELL_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic put_cell(int cx, int cy, int val);
    send_item(OP_WRITE, COL_W'($urandom), CELL_W'(cx), CELL_W'(cy), VAL_W'(val));
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and let the checker book the last accepted beat before polling outstanding
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_view(int px, int py, int dx, int dy, int plx, int ply, int sw);
    wait_idle();
    write_reg(CFG_POS_X, CFG_DATA_W'(px));
    write_reg(CFG_POS_Y, CFG_DATA_W'(py));
    write_reg(CFG_DIR_X, CFG_DATA_W'(dx));
    write_reg(CFG_DIR_Y, CFG_DATA_W'(dy));
    write_reg(CFG_PLANE_X, CFG_DATA_W'(plx));
    write_reg(CFG_PLANE_Y, CFG_DATA_W'(ply));
    write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(sw));
  endtask

  function automatic int rand_pos();
    return ($urandom_range(30, 1) << FRAC_BITS) | $urandom_range(65535);
  endfunction

  function automatic int rand_dir();
    return int'($urandom_range(262144)) - 131072;
  endfunction

  initial begin
    int mode, sw;
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= OP_WRITE;
    item_ch.column <= '0;
    item_ch.cell_x <= '0;
    item_ch.cell_y <= '0;
    item_ch.cell_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_POS_X;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty map, default view, then walls and corner cases
    cast(0);
    cast(319);
    cast(4095);
    put_cell(0, 0, 255);
    put_cell(31, 31, 1);
    put_cell(16, 16, 9);
    put_cell(10, 16, 3);
    put_cell(16, 20, 0);
    cast(160);
    cast(0);
    cast(319);
    set_view(16 << FRAC_BITS, 16 << FRAC_BITS, 0, 0, 0, 0, 320);
    cast(100);
    set_view(2097151, 0, 131072, -131072, -131072, 131072, 0);
    cast(0);
    cast(4095);
    set_view(0, 2097151, -131072, 131072, 131072, -131072, 4096);
    cast(0);
    cast(2048);
    cast(4095);
    set_view(16 << FRAC_BITS, 16 << FRAC_BITS, 0, 65536, 0, 0, 1);
    cast(0);

    // walls on the border so most rays hit
    for (int i = 0; i < 32; i++) begin
      put_cell(i, 0, $urandom_range(255, 1));
      put_cell(i, 31, $urandom_range(255, 1));
      put_cell(0, i, $urandom_range(255, 1));
      put_cell(31, i, $urandom_range(255, 1));
    end

    for (int p = 0; items_sent < TARGET_ITEMS; p++) begin
      mode = p % 4;
      sw = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(4096, 1);
      if (p % 7 == 3)
        set_view(rand_pos(), rand_pos(), 131072, -131072, -131072, 131072, sw);
      else
        set_view(rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir(), rand_dir(), sw);
      idle_pct  = (mode == 1) ? 71 : (mode == 3) ? 21 : 0;
      stall_pct = (mode == 2) ? 71 : (mode == 3) ? 21 : 0;
      if (p == 2) hold_req++;
      for (int k = 0; k < 40; k++) begin
        if (p == 5 && k == 20) begin
          item_ch.valid <= 1'b0;
          while (outstanding != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 75)
          cast(($urandom_range(3) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(sw)));
        else
          put_cell($urandom, $urandom,
                   ($urandom_range(4) == 0) ? 0 : $urandom_range(255));
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/gdda_pkg.sv
sv/gdda_if.sv
sv/gdda_div.sv
sv/gdda_dp.sv
sv/gdda_ctrl.sv
sv/grid_ray_caster_dda.sv
test/gdda_checker.sv
test/tb_top.sv
